[rtl/cpstep_pkg.sv]
// ---------------------------------------------------------------------------
// cpstep_pkg
// Types, constants and the step microprogram of the cart-pole plant.
// ---------------------------------------------------------------------------
package cpstep_pkg;

  localparam logic [15:0] STEP_LIMIT = 16'd500;
  localparam logic [15:0] CNT_MAX    = 16'hFFFF;
  localparam logic [5:0]  LAST_PC    = 6'd52;
  localparam logic [5:0]  DIV_STEPS  = 6'd56;

  localparam logic [31:0] Q_MAX         = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN         = 32'h8000_0000;
  localparam logic [31:0] Q_TWO_PI      = 32'd105414357;
  localparam logic [31:0] Q_PI          = 32'd52707179;
  localparam logic [31:0] Q_NEG_PI      = 32'hFCDB_C095;
  localparam logic [31:0] Q_HALF_PI     = 32'd26353589;
  localparam logic [31:0] Q_NEG_HALF_PI = 32'hFE6D_E04B;
  localparam logic [31:0] Q_ONE         = 32'd16777216;
  localparam logic [31:0] Q_FOUR_THIRDS = 32'd22369621;
  localparam logic [31:0] C_46          = 32'd46;
  localparam logic [31:0] C_M3329       = 32'hFFFF_F2FF;
  localparam logic [31:0] C_139810      = 32'd139810;
  localparam logic [31:0] C_M2796203    = 32'hFFD5_5555;
  localparam logic [31:0] C_M5          = 32'hFFFF_FFFB;
  localparam logic [31:0] C_416         = 32'd416;
  localparam logic [31:0] C_M23302      = 32'hFFFF_A4FA;
  localparam logic [31:0] C_699051      = 32'd699051;
  localparam logic [31:0] C_M8388608    = 32'hFF80_0000;

  typedef enum logic [2:0] {
    R_GRAVITY, R_CART_MASS, R_POLE_MASS, R_HALF_LEN,
    R_FORCE, R_TIME_STEP, R_POS_BOUND, R_ANG_BOUND
  } reg_idx_t;

  typedef struct packed {
    logic [30:0] gravity_accel;
    logic [30:0] cart_mass_value;
    logic [30:0] pole_mass_value;
    logic [30:0] pole_half_length;
    logic [30:0] push_force;
    logic [24:0] time_step;
    logic [30:0] position_bound;
    logic [30:0] angle_bound;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_MUL, OP_ADD, OP_SUB, OP_DIV, OP_MOD,
    OP_WRAP_LO, OP_WRAP_HI, OP_FOLD, OP_NEGC
  } op_t;

  typedef enum logic [4:0] {
    S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7,
    S_POS, S_VEL, S_ANG, S_RATE,
    S_G, S_MC, S_MP, S_LEN, S_FORCE, S_TAU,
    S_C46, S_CM3329, S_C139810, S_CM2796203, S_ONE,
    S_CM5, S_C416, S_CM23302, S_C699051, S_CM8388608,
    S_FOUR_THIRDS, S_TWO_PI
  } src_t;

  typedef enum logic [3:0] {
    D_T0, D_T1, D_T2, D_T3, D_T4, D_T5, D_T6, D_T7,
    D_POS, D_VEL, D_ANG, D_RATE
  } dst_t;

  typedef struct packed {
    op_t  op;
    src_t a;
    src_t b;
    dst_t dst;
  } uop_t;

  typedef enum logic [1:0] {C_IDLE, C_ISSUE, C_WAIT, C_FINISH} ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic issue;
    logic finish;
    uop_t uop;
  } ctl_cmd_t;

  typedef struct packed {
    logic op_done;
    logic out_free;
  } dp_status_t;

  function automatic logic [31:0] sat33(input logic [32:0] v);
    logic [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? Q_MIN : Q_MAX;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic uop_t mk(input op_t op, input src_t a, input src_t b, input dst_t d);
    uop_t u;
    u.op  = op;
    u.a   = a;
    u.b   = b;
    u.dst = d;
    return u;
  endfunction

  function automatic uop_t prog(input logic [5:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = mk(OP_MOD, S_ANG, S_TWO_PI, D_T0);
      6'd1:  u = mk(OP_WRAP_LO, S_T0, S_T0, D_T0);
      6'd2:  u = mk(OP_WRAP_HI, S_T0, S_T0, D_T0);
      6'd3:  u = mk(OP_FOLD, S_T0, S_T0, D_T0);
      6'd4:  u = mk(OP_MUL, S_T0, S_T0, D_T1);
      6'd5:  u = mk(OP_MUL, S_T1, S_C46, D_T2);
      6'd6:  u = mk(OP_ADD, S_T2, S_CM3329, D_T2);
      6'd7:  u = mk(OP_MUL, S_T1, S_T2, D_T2);
      6'd8:  u = mk(OP_ADD, S_T2, S_C139810, D_T2);
      6'd9:  u = mk(OP_MUL, S_T1, S_T2, D_T2);
      6'd10: u = mk(OP_ADD, S_T2, S_CM2796203, D_T2);
      6'd11: u = mk(OP_MUL, S_T1, S_T2, D_T2);
      6'd12: u = mk(OP_ADD, S_T2, S_ONE, D_T2);
      6'd13: u = mk(OP_MUL, S_T0, S_T2, D_T2);
      6'd14: u = mk(OP_MUL, S_T1, S_CM5, D_T3);
      6'd15: u = mk(OP_ADD, S_T3, S_C416, D_T3);
      6'd16: u = mk(OP_MUL, S_T1, S_T3, D_T3);
      6'd17: u = mk(OP_ADD, S_T3, S_CM23302, D_T3);
      6'd18: u = mk(OP_MUL, S_T1, S_T3, D_T3);
      6'd19: u = mk(OP_ADD, S_T3, S_C699051, D_T3);
      6'd20: u = mk(OP_MUL, S_T1, S_T3, D_T3);
      6'd21: u = mk(OP_ADD, S_T3, S_CM8388608, D_T3);
      6'd22: u = mk(OP_MUL, S_T1, S_T3, D_T3);
      6'd23: u = mk(OP_ADD, S_T3, S_ONE, D_T3);
      6'd24: u = mk(OP_NEGC, S_T3, S_T3, D_T3);
      6'd25: u = mk(OP_ADD, S_MC, S_MP, D_T0);
      6'd26: u = mk(OP_MUL, S_MP, S_LEN, D_T1);
      6'd27: u = mk(OP_MUL, S_T1, S_RATE, D_T4);
      6'd28: u = mk(OP_MUL, S_T4, S_RATE, D_T4);
      6'd29: u = mk(OP_MUL, S_T4, S_T2, D_T4);
      6'd30: u = mk(OP_ADD, S_FORCE, S_T4, D_T4);
      6'd31: u = mk(OP_DIV, S_T4, S_T0, D_T4);
      6'd32: u = mk(OP_MUL, S_G, S_T2, D_T5);
      6'd33: u = mk(OP_MUL, S_T3, S_T4, D_T6);
      6'd34: u = mk(OP_SUB, S_T5, S_T6, D_T5);
      6'd35: u = mk(OP_MUL, S_MP, S_T3, D_T6);
      6'd36: u = mk(OP_MUL, S_T6, S_T3, D_T6);
      6'd37: u = mk(OP_DIV, S_T6, S_T0, D_T6);
      6'd38: u = mk(OP_SUB, S_FOUR_THIRDS, S_T6, D_T6);
      6'd39: u = mk(OP_MUL, S_LEN, S_T6, D_T6);
      6'd40: u = mk(OP_DIV, S_T5, S_T6, D_T5);
      6'd41: u = mk(OP_MUL, S_T1, S_T5, D_T6);
      6'd42: u = mk(OP_MUL, S_T6, S_T3, D_T6);
      6'd43: u = mk(OP_DIV, S_T6, S_T0, D_T6);
      6'd44: u = mk(OP_SUB, S_T4, S_T6, D_T6);
      6'd45: u = mk(OP_MUL, S_TAU, S_VEL, D_T7);
      6'd46: u = mk(OP_ADD, S_POS, S_T7, D_POS);
      6'd47: u = mk(OP_MUL, S_TAU, S_T6, D_T7);
      6'd48: u = mk(OP_ADD, S_VEL, S_T7, D_VEL);
      6'd49: u = mk(OP_MUL, S_TAU, S_RATE, D_T7);
      6'd50: u = mk(OP_ADD, S_ANG, S_T7, D_ANG);
      6'd51: u = mk(OP_MUL, S_TAU, S_T5, D_T7);
      6'd52: u = mk(OP_ADD, S_RATE, S_T7, D_RATE);
      default: u = mk(OP_ADD, S_T0, S_T0, D_T0);
    endcase
    return u;
  endfunction

endpackage

[rtl/cpstep_regs.sv]
// ---------------------------------------------------------------------------
// cpstep_regs
// Configuration register file behind the APB-style port.
// ---------------------------------------------------------------------------
module cpstep_regs import cpstep_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  reg_idx_t idx;
  logic     wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gravity_accel    <= 31'd164416717;
      cfg.cart_mass_value  <= 31'd16777216;
      cfg.pole_mass_value  <= 31'd1677722;
      cfg.pole_half_length <= 31'd8388608;
      cfg.push_force       <= 31'd167772160;
      cfg.time_step        <= 25'd335544;
      cfg.position_bound   <= 31'd40265318;
      cfg.angle_bound      <= 31'd3513816;
    end else if (wr) begin
      case (idx)
        R_GRAVITY:   cfg.gravity_accel    <= pwdata[30:0];
        R_CART_MASS: cfg.cart_mass_value  <= pwdata[30:0];
        R_POLE_MASS: cfg.pole_mass_value  <= pwdata[30:0];
        R_HALF_LEN:  cfg.pole_half_length <= pwdata[30:0];
        R_FORCE:     cfg.push_force       <= pwdata[30:0];
        R_TIME_STEP: cfg.time_step        <= pwdata[24:0];
        R_POS_BOUND: cfg.position_bound   <= pwdata[30:0];
        R_ANG_BOUND: cfg.angle_bound      <= pwdata[30:0];
        default:     cfg.angle_bound      <= cfg.angle_bound;
      endcase
    end
  end

  always_comb begin
    case (idx)
      R_GRAVITY:   prdata = {1'b0, cfg.gravity_accel};
      R_CART_MASS: prdata = {1'b0, cfg.cart_mass_value};
      R_POLE_MASS: prdata = {1'b0, cfg.pole_mass_value};
      R_HALF_LEN:  prdata = {1'b0, cfg.pole_half_length};
      R_FORCE:     prdata = {1'b0, cfg.push_force};
      R_TIME_STEP: prdata = {7'd0, cfg.time_step};
      R_POS_BOUND: prdata = {1'b0, cfg.position_bound};
      R_ANG_BOUND: prdata = {1'b0, cfg.angle_bound};
      default:     prdata = 32'd0;
    endcase
  end

endmodule

[rtl/cpstep_ctrl.sv]
// ---------------------------------------------------------------------------
// cpstep_ctrl
// Sequencer that walks the step microprogram and hands operations to the
// datapath one at a time.
// ---------------------------------------------------------------------------
module cpstep_ctrl import cpstep_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       req_type,
  input  dp_status_t status,
  output logic       in_ready,
  output ctl_cmd_t   cmd
);

  ctrl_state_t state, state_next;
  logic [5:0]  pc, pc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      pc    <= 6'd0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
    end
  end

  always_comb begin
    state_next = state;
    pc_next    = pc;
    case (state)
      C_IDLE: begin
        if (in_valid) begin
          state_next = req_type ? C_ISSUE : C_FINISH;
          pc_next    = 6'd0;
        end
      end
      C_ISSUE: state_next = C_WAIT;
      C_WAIT: begin
        if (status.op_done) begin
          if (pc == LAST_PC) begin
            state_next = C_FINISH;
          end else begin
            state_next = C_ISSUE;
            pc_next    = pc + 6'd1;
          end
        end
      end
      C_FINISH: begin
        if (status.out_free) state_next = C_IDLE;
      end
      default: state_next = C_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = (state == C_IDLE);
    cmd.capture = (state == C_IDLE) && in_valid;
    cmd.issue   = (state == C_ISSUE);
    cmd.finish  = (state == C_FINISH) && status.out_free;
    cmd.uop     = prog(pc);
  end

endmodule

[rtl/cpstep_dp.sv]
// ---------------------------------------------------------------------------
// cpstep_dp
// Plant state, scratch store, shared multiplier, shared restoring divider
// and the output register.
// ---------------------------------------------------------------------------
module cpstep_dp import cpstep_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  ctl_cmd_t    cmd,
  input  cfg_t        cfg,
  input  logic        req_type,
  input  logic        push_right,
  input  logic [31:0] start_position,
  input  logic [31:0] start_velocity,
  input  logic [31:0] start_angle,
  input  logic [31:0] start_angular_rate,
  input  logic        out_ready,
  output dp_status_t  status,
  output logic        out_valid,
  output logic [31:0] position_out,
  output logic [31:0] velocity_out,
  output logic [31:0] angle_out,
  output logic [31:0] angular_rate_out,
  output logic        episode_done,
  output logic        reward,
  output logic [15:0] steps_taken
);

  logic [31:0] tmp_mem [8];
  logic [31:0] pos, vel, ang, rate;
  logic [15:0] cnt;
  logic        neg_cos;
  logic        h_req, h_push;
  logic [31:0] h_pos, h_vel, h_ang, h_rate;
  logic [31:0] ma, mb, oa, ob, opa, opb;
  logic        a_tmp, b_tmp;
  op_t         op_q;
  dst_t        dst_q;
  logic        pend, mul_ph, div_run;
  logic [63:0] prod;
  logic [5:0]  div_cnt;
  logic [55:0] dq;
  logic [31:0] dr, dvs;
  logic        q_neg, r_neg, dvs_zero;
  logic [31:0] force_val, res;
  logic        is_div, op_done, wr_en;
  logic [55:0] x56, mag56;
  logic [32:0] sh, sh_sub;
  logic        ge;
  logic [63:0] rx;
  logic [39:0] rsh;
  logic [31:0] mul_res, div_res, mod_res;
  logic        big;
  logic        fold_gt, fold_lt;
  logic [32:0] abs_pos, abs_ang;
  logic        done_now;

  assign force_val = h_push ? {1'b0, cfg.push_force} : 32'd0 - {1'b0, cfg.push_force};

  function automatic logic [31:0] other_val(input src_t s);
    logic [31:0] v;
    case (s)
      S_POS:         v = pos;
      S_VEL:         v = vel;
      S_ANG:         v = ang;
      S_RATE:        v = rate;
      S_G:           v = {1'b0, cfg.gravity_accel};
      S_MC:          v = {1'b0, cfg.cart_mass_value};
      S_MP:          v = {1'b0, cfg.pole_mass_value};
      S_LEN:         v = {1'b0, cfg.pole_half_length};
      S_FORCE:       v = force_val;
      S_TAU:         v = {7'd0, cfg.time_step};
      S_C46:         v = C_46;
      S_CM3329:      v = C_M3329;
      S_C139810:     v = C_139810;
      S_CM2796203:   v = C_M2796203;
      S_ONE:         v = Q_ONE;
      S_CM5:         v = C_M5;
      S_C416:        v = C_416;
      S_CM23302:     v = C_M23302;
      S_C699051:     v = C_699051;
      S_CM8388608:   v = C_M8388608;
      S_FOUR_THIRDS: v = Q_FOUR_THIRDS;
      S_TWO_PI:      v = Q_TWO_PI;
      default:       v = 32'd0;
    endcase
    return v;
  endfunction

  assign opa    = a_tmp ? ma : oa;
  assign opb    = b_tmp ? mb : ob;
  assign is_div = (op_q == OP_DIV) || (op_q == OP_MOD);

  always_comb begin
    if (op_q == OP_MUL) begin
      op_done = pend && mul_ph;
    end else if (is_div) begin
      op_done = pend && div_run && (div_cnt == 6'd0);
    end else begin
      op_done = pend;
    end
  end

  assign status.op_done  = op_done;
  assign status.out_free = !out_valid || out_ready;
  assign wr_en           = op_done;

  // Divider front end and one restoring step.
  assign x56   = (op_q == OP_DIV) ? {opa, 24'd0} : {{24{opa[31]}}, opa};
  assign mag56 = opa[31] ? 56'd0 - x56 : x56;
  assign sh     = {dr, dq[55]};
  assign sh_sub = sh - {1'b0, dvs};
  assign ge     = (sh >= {1'b0, dvs});

  // Product rounding to Q8.24.
  assign rx  = prod + 64'd8388608;
  assign rsh = rx[63:24];
  always_comb begin
    if ((&rsh[39:31]) || !(|rsh[39:31])) begin
      mul_res = rsh[31:0];
    end else begin
      mul_res = rsh[39] ? Q_MIN : Q_MAX;
    end
  end

  assign big = |dq[55:32];
  always_comb begin
    if (dvs_zero) begin
      div_res = r_neg ? Q_MIN : Q_MAX;
    end else if (q_neg) begin
      div_res = (big || (dq[31:0] > 32'h8000_0000)) ? Q_MIN : 32'd0 - dq[31:0];
    end else begin
      div_res = (big || dq[31]) ? Q_MAX : dq[31:0];
    end
  end
  assign mod_res = r_neg ? 32'd0 - dr : dr;

  assign fold_gt = $signed(opa) > $signed(Q_HALF_PI);
  assign fold_lt = $signed(opa) < $signed(Q_NEG_HALF_PI);

  always_comb begin
    case (op_q)
      OP_MUL:     res = mul_res;
      OP_ADD:     res = sat33({opa[31], opa} + {opb[31], opb});
      OP_SUB:     res = sat33({opa[31], opa} - {opb[31], opb});
      OP_DIV:     res = div_res;
      OP_MOD:     res = mod_res;
      OP_WRAP_LO: res = opa[31] ? opa + Q_TWO_PI : opa;
      OP_WRAP_HI: res = ($signed(opa) > $signed(Q_PI)) ? opa - Q_TWO_PI : opa;
      OP_FOLD:    res = fold_gt ? Q_PI - opa : (fold_lt ? Q_NEG_PI - opa : opa);
      OP_NEGC:    res = neg_cos ? 32'd0 - opa : opa;
      default:    res = opa;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      ma    <= tmp_mem[cmd.uop.a[2:0]];
      mb    <= tmp_mem[cmd.uop.b[2:0]];
      oa    <= other_val(cmd.uop.a);
      ob    <= other_val(cmd.uop.b);
      a_tmp <= (cmd.uop.a <= S_T7);
      b_tmp <= (cmd.uop.b <= S_T7);
      op_q  <= cmd.uop.op;
      dst_q <= cmd.uop.dst;
    end
    if (wr_en && (dst_q <= D_T7)) begin
      tmp_mem[dst_q[2:0]] <= res;
    end
    if (pend && (op_q == OP_MUL) && !mul_ph) begin
      prod <= 64'($signed(opa) * $signed(opb));
    end
    if (pend && is_div && !div_run) begin
      dq       <= mag56;
      dr       <= 32'd0;
      dvs      <= opb[31] ? 32'd0 - opb : opb;
      q_neg    <= opa[31] ^ opb[31];
      r_neg    <= opa[31];
      dvs_zero <= (opb == 32'd0);
    end else if (div_run && (div_cnt != 6'd0)) begin
      dr <= ge ? sh_sub[31:0] : sh[31:0];
      dq <= {dq[54:0], ge};
    end
    if (cmd.capture) begin
      h_req  <= req_type;
      h_push <= push_right;
      h_pos  <= start_position;
      h_vel  <= start_velocity;
      h_ang  <= start_angle;
      h_rate <= start_angular_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend    <= 1'b0;
      mul_ph  <= 1'b0;
      div_run <= 1'b0;
      div_cnt <= 6'd0;
      neg_cos <= 1'b0;
    end else begin
      if (cmd.issue) begin
        pend <= 1'b1;
      end else if (op_done) begin
        pend <= 1'b0;
      end
      mul_ph <= pend && (op_q == OP_MUL) && !mul_ph;
      if (pend && is_div && !div_run) begin
        div_run <= 1'b1;
        div_cnt <= DIV_STEPS;
      end else if (div_run && (div_cnt != 6'd0)) begin
        div_cnt <= div_cnt - 6'd1;
      end else if (op_done) begin
        div_run <= 1'b0;
      end
      if (op_done && (op_q == OP_FOLD)) begin
        neg_cos <= fold_gt || fold_lt;
      end
    end
  end

  assign abs_pos  = pos[31] ? 33'd0 - {pos[31], pos} : {1'b0, pos};
  assign abs_ang  = ang[31] ? 33'd0 - {ang[31], ang} : {1'b0, ang};
  assign done_now = (abs_pos > {2'b0, cfg.position_bound}) ||
                    (abs_ang > {2'b0, cfg.angle_bound}) || (cnt >= STEP_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= 32'd0;
      vel       <= 32'd0;
      ang       <= 32'd0;
      rate      <= 32'd0;
      cnt       <= 16'd0;
      out_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        case (dst_q)
          D_POS:   pos  <= res;
          D_VEL:   vel  <= res;
          D_ANG:   ang  <= res;
          D_RATE:  rate <= res;
          default: pos  <= pos;
        endcase
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        if (!h_req) begin
          pos  <= h_pos;
          vel  <= h_vel;
          ang  <= h_ang;
          rate <= h_rate;
          cnt  <= 16'd0;
        end else if (cnt != CNT_MAX) begin
          cnt <= cnt + 16'd1;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (!h_req) begin
        position_out     <= h_pos;
        velocity_out     <= h_vel;
        angle_out        <= h_ang;
        angular_rate_out <= h_rate;
        episode_done     <= 1'b0;
        reward           <= 1'b0;
        steps_taken      <= 16'd0;
      end else begin
        position_out     <= pos;
        velocity_out     <= vel;
        angle_out        <= ang;
        angular_rate_out <= rate;
        episode_done     <= done_now;
        reward           <= !done_now;
        steps_taken      <= (cnt != CNT_MAX) ? cnt + 16'd1 : cnt;
      end
    end
  end

endmodule

[rtl/cartpole_physics_step_top.sv]
// ---------------------------------------------------------------------------
// cartpole_physics_step_top
// Cart-pole plant: start and Euler step requests in Q8.24 fixed point.
//
//   Channel   Handshake                  Payload
//   input     in_valid / in_ready        req_type, push_right, start_*
//   output    out_valid / out_ready      position_out .. steps_taken
//   config    psel, penable, pwrite      paddr, pwdata, prdata
//
// A start request skips the microprogram. A step request runs 53
// microprogram operations through one shared multiplier and one restoring
// divider, whose five divide operations dominate the run time of a step.
// Reset is synchronous and active high; it restores the register defaults.
// A finished result waits in the output register; a stalled output holds
// the next result back only at its final write.
// ---------------------------------------------------------------------------
module cartpole_physics_step_top import cpstep_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic        push_right,
  input  logic [31:0] start_position,
  input  logic [31:0] start_velocity,
  input  logic [31:0] start_angle,
  input  logic [31:0] start_angular_rate,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] position_out,
  output logic [31:0] velocity_out,
  output logic [31:0] angle_out,
  output logic [31:0] angular_rate_out,
  output logic        episode_done,
  output logic        reward,
  output logic [15:0] steps_taken,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg;
  ctl_cmd_t   cmd;
  dp_status_t status;

  cpstep_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cpstep_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  cpstep_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .cfg                (cfg),
    .req_type           (req_type),
    .push_right         (push_right),
    .start_position     (start_position),
    .start_velocity     (start_velocity),
    .start_angle        (start_angle),
    .start_angular_rate (start_angular_rate),
    .out_ready          (out_ready),
    .status             (status),
    .out_valid          (out_valid),
    .position_out       (position_out),
    .velocity_out       (velocity_out),
    .angle_out          (angle_out),
    .angular_rate_out   (angular_rate_out),
    .episode_done       (episode_done),
    .reward             (reward),
    .steps_taken        (steps_taken)
  );

endmodule

[rtl/cpstep_chk.sv]
// ---------------------------------------------------------------------------
// cpstep_chk
// Port-level checks for the cart-pole plant, bound to the top level.
// ---------------------------------------------------------------------------
module cpstep_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] position_out,
  input logic        episode_done,
  input logic        reward,
  input logic [15:0] steps_taken
);

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a request is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(position_out)))
    else $error("stalled result changed or dropped");

  a_done_no_reward: assert property (@(posedge clk) disable iff (rst)
    (out_valid && episode_done) |-> !reward)
    else $error("reward given on a finished episode");

  a_start_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (steps_taken == 16'd0)) |-> (!episode_done && !reward))
    else $error("start result carries done or reward");

endmodule

bind cartpole_physics_step_top cpstep_chk u_chk (.*);

[test/tb_cartpole_physics_step_top.sv]
// ---------------------------------------------------------------------------
// tb_cartpole_physics_step_top
// Self-checking testbench for the cart-pole plant.
//
// Start and step requests are sent over the input channel. A scoreboard class
// predicts each result in Q8.24 fixed point and compares it field by field
// with each transfer on the output channel. The run passes through several
// register settings, including all-zero and all-maximum values, and through
// three idling patterns. One long receiver hold-off fills the block.
// ---------------------------------------------------------------------------
module tb_cartpole_physics_step_top;

  timeunit 1ns;
  timeprecision 1ps;

  import cpstep_pkg::*;

  typedef struct packed {
    logic [31:0] pos;
    logic [31:0] vel;
    logic [31:0] ang;
    logic [31:0] rate;
    logic        done;
    logic        rew;
    logic [15:0] steps;
  } plant_result_t;

  class plant_scoreboard;
    longint        cfg[8];
    longint        pos, vel, ang, rate;
    int            counter;
    plant_result_t expected_q[$];
    int            mismatches;

    function new();
      cfg[R_GRAVITY]   = 164416717;
      cfg[R_CART_MASS] = 16777216;
      cfg[R_POLE_MASS] = 1677722;
      cfg[R_HALF_LEN]  = 8388608;
      cfg[R_FORCE]     = 167772160;
      cfg[R_TIME_STEP] = 335544;
      cfg[R_POS_BOUND] = 40265318;
      cfg[R_ANG_BOUND] = 3513816;
      pos = 0;
      vel = 0;
      ang = 0;
      rate = 0;
      counter = 0;
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] value);
      if (idx == R_TIME_STEP) cfg[idx] = longint'(value & 32'h01FF_FFFF);
      else cfg[idx] = longint'(value & 32'h7FFF_FFFF);
    endfunction

    function longint clip(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint fmul(longint a, longint b);
      longint x;
      x = a * b + 64'sd8388608;
      return clip(x >>> 24);
    endfunction

    function longint fdiv(longint a, longint b);
      if (b == 0) return (a >= 0) ? 64'sd2147483647 : -64'sd2147483648;
      return clip((a * 64'sd16777216) / b);
    endfunction

    function longint sq(logic [31:0] c);
      return longint'($signed(c));
    endfunction

    function void sin_cos(longint theta, output longint s, output longint c);
      longint r, x2, p;
      bit flip;
      flip = 0;
      r = theta % sq(Q_TWO_PI);
      if (r < 0) r += sq(Q_TWO_PI);
      if (r > sq(Q_PI)) r -= sq(Q_TWO_PI);
      if (r > sq(Q_HALF_PI)) begin
        r = sq(Q_PI) - r;
        flip = 1;
      end else if (r < -sq(Q_HALF_PI)) begin
        r = -sq(Q_PI) - r;
        flip = 1;
      end
      x2 = fmul(r, r);
      p = sq(C_46);
      p = clip(sq(C_M3329) + fmul(x2, p));
      p = clip(sq(C_139810) + fmul(x2, p));
      p = clip(sq(C_M2796203) + fmul(x2, p));
      p = clip(sq(Q_ONE) + fmul(x2, p));
      s = fmul(r, p);
      p = sq(C_M5);
      p = clip(sq(C_416) + fmul(x2, p));
      p = clip(sq(C_M23302) + fmul(x2, p));
      p = clip(sq(C_699051) + fmul(x2, p));
      p = clip(sq(C_M8388608) + fmul(x2, p));
      p = clip(sq(Q_ONE) + fmul(x2, p));
      c = flip ? -p : p;
    endfunction

    function void note_request(logic rt, logic pr, logic [31:0] sp, logic [31:0] sv,
                               logic [31:0] sa, logic [31:0] sr);
      plant_result_t e;
      longint sn, cs, total, force_v, t, temp, num, q, den, th_acc, x_acc, vel0, rate0;
      longint abs_pos, abs_ang;
      e.done = 0;
      e.rew = 0;
      if (!rt) begin
        pos = sq(sp);
        vel = sq(sv);
        ang = sq(sa);
        rate = sq(sr);
        counter = 0;
      end else begin
        force_v = pr ? cfg[R_FORCE] : -cfg[R_FORCE];
        vel0 = vel;
        rate0 = rate;
        sin_cos(ang, sn, cs);
        total = clip(cfg[R_CART_MASS] + cfg[R_POLE_MASS]);
        t = fmul(fmul(fmul(fmul(cfg[R_POLE_MASS], cfg[R_HALF_LEN]), rate0), rate0), sn);
        temp = fdiv(clip(force_v + t), total);
        num = clip(fmul(cfg[R_GRAVITY], sn) - fmul(cs, temp));
        q = fdiv(fmul(fmul(cfg[R_POLE_MASS], cs), cs), total);
        den = fmul(cfg[R_HALF_LEN], clip(sq(Q_FOUR_THIRDS) - q));
        th_acc = fdiv(num, den);
        x_acc = clip(temp - fdiv(fmul(fmul(fmul(cfg[R_POLE_MASS], cfg[R_HALF_LEN]),
                                               th_acc), cs), total));
        pos = clip(pos + fmul(cfg[R_TIME_STEP], vel0));
        vel = clip(vel + fmul(cfg[R_TIME_STEP], x_acc));
        ang = clip(ang + fmul(cfg[R_TIME_STEP], rate0));
        rate = clip(rate + fmul(cfg[R_TIME_STEP], th_acc));
        abs_pos = (pos < 0) ? -pos : pos;
        abs_ang = (ang < 0) ? -ang : ang;
        e.done = (abs_pos > cfg[R_POS_BOUND]) || (abs_ang > cfg[R_ANG_BOUND]) ||
                 (counter >= int'(STEP_LIMIT));
        e.rew = !e.done;
        if (counter < int'(CNT_MAX)) counter++;
      end
      e.pos = pos[31:0];
      e.vel = vel[31:0];
      e.ang = ang[31:0];
      e.rate = rate[31:0];
      e.steps = counter[15:0];
      expected_q.push_back(e);
    endfunction

    function void check_result(plant_result_t got);
      plant_result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output transfer at %0t", $realtime);
        return;
      end
      e = expected_q.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t: expected pos=%h vel=%h ang=%h rate=%h done=%b rew=%b",
                   $realtime, e.pos, e.vel, e.ang, e.rate, e.done, e.rew);
          $display("  expected steps=%0d, got pos=%h vel=%h ang=%h rate=%h done=%b rew=%b",
                   e.steps, got.pos, got.vel, got.ang, got.rate, got.done, got.rew);
          $display("  got steps=%0d", got.steps);
        end
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic        req_type = 0;
  logic        push_right = 0;
  logic [31:0] start_position = 0;
  logic [31:0] start_velocity = 0;
  logic [31:0] start_angle = 0;
  logic [31:0] start_angular_rate = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] position_out, velocity_out, angle_out, angular_rate_out;
  logic        episode_done, reward;
  logic [15:0] steps_taken;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [4:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  int send_idle = 0;
  int recv_idle = 0;
  int hold_left = 0;
  plant_scoreboard sb = new();

  cartpole_physics_step_top dut (.*);

  always #2 clk = ~clk;

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else if (hold_left > 0) begin
      out_ready <= 0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    plant_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.pos = position_out;
      got.vel = velocity_out;
      got.ang = angle_out;
      got.rate = angular_rate_out;
      got.done = episode_done;
      got.rew = reward;
      got.steps = steps_taken;
      sb.check_result(got);
    end
  end

  task automatic send_req(logic rt, logic pr, logic [31:0] sp, logic [31:0] sv,
                          logic [31:0] sa, logic [31:0] sr);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    req_type <= rt;
    push_right <= pr;
    start_position <= sp;
    start_velocity <= sv;
    start_angle <= sa;
    start_angular_rate <= sr;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(rt, pr, sp, sv, sa, sr);
  endtask

  task automatic step_cart(logic pr);
    send_req(1'b1, pr, $urandom, $urandom, $urandom, $urandom);
  endtask

  function automatic logic [31:0] rand_state(int span);
    if ($urandom_range(0, 7) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic start_episode();
    send_req(1'b0, $urandom_range(0, 1), rand_state(1 << 23), rand_state(1 << 24),
             rand_state(1 << 21), rand_state(1 << 23));
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= 5'(idx) << 2;
    pwdata <= value;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    sb.set_reg(idx, value);
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  task automatic random_episodes(int n_items);
    int sent, len;
    sent = 0;
    while (sent < n_items) begin
      start_episode();
      sent++;
      len = $urandom_range(1, 40);
      for (int k = 0; k < len && sent < n_items; k++) begin
        if ($urandom_range(0, 29) == 0) start_episode();
        else step_cart($urandom_range(0, 1));
        sent++;
      end
    end
  endtask

  task automatic write_all(logic [31:0] v[8]);
    for (int k = 0; k < 8; k++) write_reg(reg_idx_t'(k), v[k]);
  endtask

  initial begin
    logic [31:0] v[8];
    repeat (7) @(negedge clk);
    rst <= 0;

    send_idle = 36;
    recv_idle = 54;
    send_req(1'b1, 1'b1, 0, 0, 0, 0);
    send_req(1'b1, 1'b0, 0, 0, 0, 0);
    send_req(1'b0, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    step_cart(1'b1);
    step_cart(1'b0);
    send_req(1'b0, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    step_cart(1'b0);
    step_cart(1'b1);
    send_req(1'b0, 1'b0, 0, 0, Q_PI, 0);
    step_cart(1'b1);
    send_req(1'b0, 1'b0, 0, 0, Q_HALF_PI + 1, 32'h0100_0000);
    step_cart(1'b0);
    send_req(1'b0, 1'b0, 0, 0, Q_NEG_HALF_PI - 1, 32'hFF00_0000);
    step_cart(1'b1);
    send_req(1'b0, 1'b0, 0, 0, Q_NEG_PI, 0);
    step_cart(1'b1);
    send_req(1'b0, 1'b0, 32'h0300_0000, 32'h0100_0000, 0, 0);
    step_cart(1'b1);
    send_req(1'b0, 1'b0, 0, 0, 32'h0040_0000, 0);
    step_cart(1'b0);
    random_episodes(260);
    drain();

    v[R_GRAVITY] = $urandom_range(0, 1 << 28);
    v[R_CART_MASS] = $urandom_range(1 << 22, 1 << 26);
    v[R_POLE_MASS] = $urandom_range(0, 1 << 25);
    v[R_HALF_LEN] = $urandom_range(1 << 22, 1 << 26);
    v[R_FORCE] = $urandom_range(0, 1 << 28);
    v[R_TIME_STEP] = $urandom_range(0, 1 << 24);
    v[R_POS_BOUND] = $urandom_range(0, 1 << 27);
    v[R_ANG_BOUND] = $urandom_range(0, 1 << 24);
    write_all(v);
    hold_left = 3000;
    random_episodes(250);
    drain();

    send_idle = 54;
    recv_idle = 36;
    for (int k = 0; k < 8; k++) v[k] = 32'h7FFF_FFFF;
    v[R_TIME_STEP] = 32'h01FF_FFFF;
    write_all(v);
    random_episodes(250);
    drain();

    for (int k = 0; k < 8; k++) v[k] = 0;
    write_all(v);
    random_episodes(250);
    drain();

    send_idle = 0;
    recv_idle = 0;
    for (int k = 0; k < 8; k++) v[k] = $urandom;
    write_all(v);
    random_episodes(250);
    drain();

    v[R_GRAVITY] = 164416717;
    v[R_CART_MASS] = 16777216;
    v[R_POLE_MASS] = 1677722;
    v[R_HALF_LEN] = 8388608;
    v[R_FORCE] = 167772160;
    v[R_TIME_STEP] = 335544;
    v[R_POS_BOUND] = 32'h7FFF_FFFF;
    v[R_ANG_BOUND] = 32'h7FFF_FFFF;
    write_all(v);
    send_req(1'b0, 1'b0, 0, 0, 0, 0);
    for (int k = 0; k < 520; k++) step_cart(k[0]);
    drain();

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
